// File: hw/rtl/btmx_pkg.sv
// btmx_pkg: shared constants and types for the minimum-xor trie matcher
// field widths, parameter defaults, operation and status codes
// no dependencies
package btmx_pkg;

  // parameter defaults
  localparam int KEY_BITS_DEF  = 30;
  localparam int MAX_NODES_DEF = 65536;

  // field widths on the stream ports
  localparam int KEY_W      = 30;
  localparam int STS_W      = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  // per-node count and stored-key total
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // operation codes carried on in_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // result status carried on out_tuser
  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

endpackage

// File: hw/rtl/btmx_ram.sv
// btmx_ram: generic single-write, single-read ram with registered read data
// used for the trie link and count stores; no dependencies
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/binary_trie_min_xor_match.sv
// binary_trie_min_xor_match: counted binary trie, insert and min-xor query with removal
// one transaction at a time; each trie level is one pass through the link and count rams
// (insert: LINK, STEP, UPD; query: LINK, STEP, PICK, UPD); a refused or empty item goes straight to OUT
// (ram read latency sets the per-level cost); the next item is taken once the result is queued
// reset (rst_n low, synchronous) starts a clearing pass over every entry of both rams,
// in_tready stays low until it ends; depends on btmx_pkg and btmx_ram
module binary_trie_min_xor_match #(
  parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
  parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [btmx_pkg::IN_DATA_W-1:0]   in_tdata,   // [29:0] key_value
  input  logic                             in_tuser,   // [0] op
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [btmx_pkg::OUT_DATA_W-1:0]  out_tdata,  // [29:0] xor_result, [59:30] matched_value
  output logic [btmx_pkg::STS_W-1:0]       out_tuser   // [1:0] status
);
  import btmx_pkg::*;

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(MAX_NODES - 1);
  localparam logic [NODE_W-1:0] NF_LIMIT  = NODE_W'(MAX_NODES - 1 - KEY_BITS);
  localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(KEY_BITS - 1);

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_LINK = 7'b0000100,
    ST_STEP = 7'b0001000,
    ST_PICK = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  // control state
  state_t                state_r, state_nxt;
  logic [NODE_W-1:0]     clr_r, clr_nxt;
  logic [NODE_W-1:0]     nf_r, nf_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  // walk payload
  logic                  op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [KEY_BITS-1:0]   match_r, match_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [NODE_W-1:0]     node_r, node_nxt;
  logic [NODE_W-1:0]     same_r, same_nxt;
  logic [NODE_W-1:0]     opp_r, opp_nxt;
  status_t               sts_r, sts_nxt;
  // result register
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  status_t               out_sts_r, out_sts_nxt;

  // ram ports
  logic                  lnk_we;
  logic [NODE_W-1:0]     lnk_waddr, lnk_raddr;
  logic [2*NODE_W-1:0]   lnk_wdata, lnk_rdata;
  logic                  cnt_we;
  logic [NODE_W-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;

  // walk helpers
  logic                  kbit;
  logic [NODE_W-1:0]     l0, l1, same_c, opp_c, new_node;
  logic                  pick_bit;
  logic [NODE_W-1:0]     pick_node;
  logic [KEY_W-1:0]      key_f, match_f;

  btmx_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_NODES), .AW(NODE_W)) u_links (
    .clk(clk), .wr_en(lnk_we), .wr_addr(lnk_waddr), .wr_data(lnk_wdata),
    .rd_addr(lnk_raddr), .rd_data(lnk_rdata)
  );

  btmx_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES), .AW(NODE_W)) u_counts (
    .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
    .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
  );

  // current key bit and children of the node being walked
  assign kbit     = key_r[lvl_r];
  assign l0       = lnk_rdata[NODE_W-1:0];
  assign l1       = lnk_rdata[2*NODE_W-1:NODE_W];
  assign same_c   = kbit ? l1 : l0;
  assign opp_c    = kbit ? l0 : l1;
  assign new_node = nf_r + 1'b1;

  // query branch choice: matching child while it holds keys, else the other one if linked, else the matching one
  always_comb begin
    if ((same_r != '0) && (cnt_rdata != '0)) begin
      pick_bit  = kbit;
      pick_node = same_r;
    end else if (opp_r != '0) begin
      pick_bit  = ~kbit;
      pick_node = opp_r;
    end else begin
      pick_bit  = kbit;
      pick_node = same_r;
    end
  end

  assign key_f   = KEY_W'(64'(key_r));
  assign match_f = KEY_W'(64'(match_r));

  // sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nf_nxt        = nf_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    match_nxt     = match_r;
    lvl_nxt       = lvl_r;
    node_nxt      = node_r;
    same_nxt      = same_r;
    opp_nxt       = opp_r;
    sts_nxt       = sts_r;
    out_data_nxt  = out_data_r;
    out_sts_nxt   = out_sts_r;
    lnk_we        = 1'b0;
    lnk_waddr     = node_r;
    lnk_wdata     = lnk_rdata;
    lnk_raddr     = node_r;
    cnt_we        = 1'b0;
    cnt_waddr     = node_r;
    cnt_wdata     = cnt_rdata;
    cnt_raddr     = node_r;

    // result register drains independently of the walk
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        lnk_we    = 1'b1;
        lnk_waddr = clr_r;
        lnk_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == NODE_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          key_nxt   = KEY_BITS'(64'(in_tdata[KEY_W-1:0]));
          match_nxt = '0;
          lvl_nxt   = LVL_TOP;
          node_nxt  = '0;
          sts_nxt   = STS_DONE;
          state_nxt = ST_LINK;
          if (in_tuser == OP_INSERT) begin
            if ((nf_r > NF_LIMIT) || (total_r == CNT_MAX)) begin
              sts_nxt   = STS_FULL;
              state_nxt = ST_OUT;
            end
          end else if (total_r == '0) begin
            sts_nxt   = STS_EMPTY;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_LINK: begin
        lnk_raddr = node_r;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (op_r == OP_INSERT) begin
          // follow or create the child for this key bit
          if (same_c == '0) begin
            nf_nxt    = new_node;
            node_nxt  = new_node;
            lnk_we    = 1'b1;
            lnk_waddr = node_r;
            lnk_wdata = kbit ? {new_node, l0} : {l1, new_node};
            cnt_raddr = new_node;
          end else begin
            node_nxt  = same_c;
            cnt_raddr = same_c;
          end
          state_nxt = ST_UPD;
        end else begin
          same_nxt  = same_c;
          opp_nxt   = opp_c;
          cnt_raddr = same_c;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        match_nxt[lvl_r] = pick_bit;
        node_nxt         = pick_node;
        cnt_raddr        = pick_node;
        state_nxt        = ST_UPD;
      end
      ST_UPD: begin
        // count update on the child just entered
        cnt_waddr = node_r;
        if (op_r == OP_INSERT) begin
          cnt_we    = (cnt_rdata != CNT_MAX);
          cnt_wdata = cnt_rdata + 1'b1;
        end else begin
          cnt_we    = (node_r != '0) && (cnt_rdata != '0);
          cnt_wdata = cnt_rdata - 1'b1;
        end
        if (lvl_r == '0) begin
          total_nxt = (op_r == OP_INSERT) ? total_r + 1'b1 : total_r - 1'b1;
          state_nxt = ST_OUT;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = ST_LINK;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = sts_r;
          if ((sts_r == STS_DONE) && (op_r == OP_QUERY)) begin
            out_data_nxt = {{(OUT_DATA_W - 2 * KEY_W){1'b0}}, match_f, key_f ^ match_f};
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      nf_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nf_r        <= nf_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    match_r    <= match_nxt;
    lvl_r      <= lvl_nxt;
    node_r     <= node_nxt;
    same_r     <= same_nxt;
    opp_r      <= opp_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sts_r;

  // a query count write never takes a zero count below zero
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && op_r == OP_QUERY && cnt_we) |-> (cnt_rdata != '0))
    else $error("count decrement from zero");

  // a completed query always had at least one stored key
  a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && op_r == OP_QUERY && lvl_r == '0) |-> (total_r != '0))
    else $error("query finished on empty store");

  // link writes only come from the clearing pass or an insert step
  a_link_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    lnk_we |-> (state_r == ST_CLR || (state_r == ST_STEP && op_r == OP_INSERT)))
    else $error("unexpected link write");

  // a new node is only allocated while the free pointer is still below the last pool entry
  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLR && nf_r != $past(nf_r)) |-> ($past(nf_r) < NODE_LAST))
    else $error("node pool overrun");

endmodule
